>>> design/assert_macros.svh
// Assertion helpers for the RTL files that check their own logic (used by mdfm_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/mdfm_pkg.sv
`default_nettype none

package mdfm_pkg;

    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int NOM_W      = 20;

    localparam logic [15:0] DEPTH_ONE  = 16'd32768;
    localparam int          SLEW_COEF  = 66;
    localparam int          SLEW_ROUND = 32768;
    localparam int          MOD_GAIN   = 125;
    localparam logic [19:0] NOM_RESET  = 20'd61440;

    typedef enum logic [1:0] {
        REG_BASE_DEPTH    = 2'd0,
        REG_CV_ATTEN      = 2'd1,
        REG_CV_ENABLED    = 2'd2,
        REG_NOMINAL_DELAY = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]      base_depth;
        logic [15:0]      cv_atten;
        logic             cv_enabled;
        logic [NOM_W-1:0] nominal_delay;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TARGET,
        ST_SLEW,
        ST_MODMUL,
        ST_POS,
        ST_WRAP,
        ST_INTERP
    } state_t;

endpackage

`default_nettype wire

>>> design/mdfm_cfg.sv
`default_nettype none

module mdfm_cfg
    import mdfm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BASE_DEPTH:    cfg_next.base_depth    = pwdata[15:0];
                REG_CV_ATTEN:      cfg_next.cv_atten      = pwdata[15:0];
                REG_CV_ENABLED:    cfg_next.cv_enabled    = pwdata[0];
                REG_NOMINAL_DELAY: cfg_next.nominal_delay = pwdata[NOM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_depth    <= '0;
            cfg_reg.cv_atten      <= '0;
            cfg_reg.cv_enabled    <= 1'b0;
            cfg_reg.nominal_delay <= NOM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BASE_DEPTH:    prdata = {16'd0, cfg_reg.base_depth};
            REG_CV_ATTEN:      prdata = {{16{cfg_reg.cv_atten[15]}}, cfg_reg.cv_atten};
            REG_CV_ENABLED:    prdata = {31'd0, cfg_reg.cv_enabled};
            REG_NOMINAL_DELAY: prdata = {{(APB_DW-NOM_W){1'b0}}, cfg_reg.nominal_delay};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/mdfm_delay_ram.sv
`default_nettype none

module mdfm_delay_ram
    import mdfm_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
)(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic        [AW-1:0] waddr,
    input  wire logic signed [DW-1:0] wdata,
    input  wire logic                 re,
    input  wire logic        [AW-1:0] raddr_a,
    input  wire logic        [AW-1:0] raddr_b,
    output logic signed      [DW-1:0] rdata_a,
    output logic signed      [DW-1:0] rdata_b
);

    logic signed [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/mdfm_core.sv
`default_nettype none
`include "assert_macros.svh"

module mdfm_core
    import mdfm_pkg::*;
#(
    parameter int BUFFER_DEPTH = 4096,
    parameter int CHANNELS     = 16,
    parameter int SAMPLE_BITS  = 16,
    localparam int MEM_AW      = $clog2(CHANNELS * BUFFER_DEPTH),
    localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfg_t                          cfg,
    input  wire logic                          clearing,
    input  wire logic              [CH_AW-1:0] clr_ch,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                    [3:0] s_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] s_carrier,
    input  wire logic signed [SAMPLE_BITS-1:0] s_mod,
    input  wire logic signed [SAMPLE_BITS-1:0] s_cv,
    input  wire logic                          s_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                         [3:0] m_channel,
    output logic signed      [SAMPLE_BITS-1:0] m_sample,
    output logic                               m_last,
    output logic                               ram_we,
    output logic                  [MEM_AW-1:0] ram_waddr,
    output logic signed      [SAMPLE_BITS-1:0] ram_wdata,
    output logic                               ram_re,
    output logic                  [MEM_AW-1:0] ram_raddr_a,
    output logic                  [MEM_AW-1:0] ram_raddr_b,
    input  wire logic signed [SAMPLE_BITS-1:0] ram_rdata_a,
    input  wire logic signed [SAMPLE_BITS-1:0] ram_rdata_b
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int POS_W = ((AW + 8 > NOM_W) ? AW + 8 : NOM_W) + 2;
    localparam int SPAN  = BUFFER_DEPTH * 256;

    state_t state_reg;
    state_t state_next;

    logic                  [3:0] ch_reg;
    logic signed        [SB-1:0] carrier_reg;
    logic signed        [SB-1:0] mod_reg;
    logic                        last_reg;
    logic signed       [SB+15:0] cv_prod_reg;
    logic                 [15:0] depth_rd_reg;
    logic                 [15:0] target_reg;
    logic                 [15:0] target_next;
    logic                 [15:0] depth_new_reg;
    logic                 [15:0] depth_new_next;
    logic signed       [SB+16:0] mod_prod_reg;
    logic signed       [SB+16:0] mod_prod_next;
    logic signed     [POS_W-1:0] pos_reg;
    logic signed     [POS_W-1:0] pos_next;
    logic                  [7:0] frac_reg;
    logic               [AW-1:0] wp_reg;
    logic               [AW-1:0] wp_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic                  [3:0] m_channel_reg;
    logic signed        [SB-1:0] m_sample_reg;
    logic signed        [SB-1:0] m_sample_next;
    logic                        m_last_reg;

    logic [15:0] depth_mem [CHANNELS];

    logic                  accept;
    logic                  ch_ok;
    logic      [CH_AW-1:0] ch_idx;
    logic                  depth_we;
    logic                  out_load;
    logic                  wrap_done;
    logic                  w_neg;
    logic                  w_over;
    logic         [AW-1:0] rd_i0;
    logic         [AW-1:0] rd_i1;
    logic     [MEM_AW-1:0] ch_base;
    logic signed [POS_W-1:0] pos_calc;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !clearing;
    assign ch_ok   = ({1'b0, ch_reg} < 5'(CHANNELS));
    assign ch_idx  = ch_reg[CH_AW-1:0];
    assign ch_base = MEM_AW'(ch_reg) * MEM_AW'(BUFFER_DEPTH);

    assign m_valid   = m_valid_reg;
    assign m_channel = m_channel_reg;
    assign m_sample  = m_sample_reg;
    assign m_last    = m_last_reg;

    // target depth: knob plus scaled CV when enabled, clamped to 0..1
    always_comb
    begin
        logic signed [SB+15:0] cv_shift;
        logic signed [18:0]    cv_term;
        logic signed [19:0]    target_sum;
        cv_shift   = cv_prod_reg >>> (SB - 2);
        cv_term    = cv_shift[18:0];
        target_sum = signed'({4'd0, cfg.base_depth});
        if (cfg.cv_enabled)
        begin
            target_sum = target_sum + signed'({cv_term[18], cv_term});
        end
        if (target_sum < 20'sd0)
        begin
            target_next = '0;
        end
        else if (target_sum > signed'({4'd0, DEPTH_ONE}))
        begin
            target_next = DEPTH_ONE;
        end
        else
        begin
            target_next = target_sum[15:0];
        end
    end

    // one-pole slew toward the target
    always_comb
    begin
        logic signed [17:0] sl_diff;
        logic signed [24:0] sl_scaled;
        logic signed [24:0] sl_shift;
        logic signed [17:0] sl_sum;
        sl_diff   = signed'({2'd0, target_reg}) - signed'({2'd0, depth_rd_reg});
        sl_scaled = signed'({{7{sl_diff[17]}}, sl_diff}) * signed'(25'(SLEW_COEF))
                  + signed'(25'(SLEW_ROUND));
        sl_shift  = sl_scaled >>> 16;
        sl_sum    = signed'({2'd0, depth_rd_reg}) + sl_shift[17:0];
        if (sl_sum < 18'sd0)
        begin
            depth_new_next = '0;
        end
        else if (sl_sum > signed'({2'd0, DEPTH_ONE}))
        begin
            depth_new_next = DEPTH_ONE;
        end
        else
        begin
            depth_new_next = sl_sum[15:0];
        end
    end

    assign mod_prod_next = mod_reg * signed'({1'b0, depth_new_reg});

    // read position before wrapping
    always_comb
    begin
        logic signed [SB+24:0] off_full;
        logic signed [SB+24:0] off_shift;
        off_full  = mod_prod_reg * signed'(8'(MOD_GAIN));
        off_shift = off_full >>> (SB + 4);
        pos_calc  = signed'(POS_W'({wp_reg, 8'd0}))
                  - signed'(POS_W'(cfg.nominal_delay))
                  + signed'(off_shift[POS_W-1:0]);
    end

    assign w_neg     = pos_reg[POS_W-1];
    assign w_over    = !w_neg && (pos_reg >= signed'(POS_W'(SPAN)));
    assign wrap_done = !w_neg && !w_over;
    assign rd_i0     = pos_reg[AW+7:8];
    assign rd_i1     = (rd_i0 == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_i0 + 1'b1;

    always_comb
    begin
        case (state_reg)
            ST_POS:  pos_next = pos_calc;
            ST_WRAP:
            begin
                if (w_neg)
                begin
                    pos_next = pos_reg + signed'(POS_W'(SPAN));
                end
                else if (w_over)
                begin
                    pos_next = pos_reg - signed'(POS_W'(SPAN));
                end
                else
                begin
                    pos_next = pos_reg;
                end
            end
            default: pos_next = pos_reg;
        endcase
    end

    // linear interpolation between the two neighbors
    always_comb
    begin
        logic signed [SB:0]   ip_diff;
        logic signed [SB+9:0] ip_prod;
        logic signed [SB+9:0] ip_sum;
        ip_diff = signed'({ram_rdata_b[SB-1], ram_rdata_b})
                - signed'({ram_rdata_a[SB-1], ram_rdata_a});
        ip_prod = signed'({1'b0, frac_reg}) * ip_diff;
        ip_sum  = signed'({{10{ram_rdata_a[SB-1]}}, ram_rdata_a}) + (ip_prod >>> 8);
        m_sample_next = ch_ok ? ip_sum[SB-1:0] : '0;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        depth_we   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET:
            begin
                ram_we     = ch_ok;
                state_next = ST_SLEW;
            end
            ST_SLEW:
            begin
                depth_we   = ch_ok;
                state_next = ST_MODMUL;
            end
            ST_MODMUL:
            begin
                state_next = ST_POS;
            end
            ST_POS:
            begin
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (wrap_done)
                begin
                    ram_re     = ch_ok;
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_waddr   = ch_base + MEM_AW'(wp_reg);
    assign ram_wdata   = carrier_reg;
    assign ram_raddr_a = ch_base + MEM_AW'(rd_i0);
    assign ram_raddr_b = ch_base + MEM_AW'(rd_i1);

    always_comb
    begin
        wp_next = wp_reg;
        if (out_load && last_reg)
        begin
            wp_next = (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg      <= s_channel;
            carrier_reg <= s_carrier;
            mod_reg     <= s_mod;
            last_reg    <= s_last;
            cv_prod_reg <= s_cv * signed'(cfg.cv_atten);
        end
        if (state_reg == ST_TARGET)
        begin
            target_reg <= target_next;
        end
        if (state_reg == ST_SLEW)
        begin
            depth_new_reg <= depth_new_next;
        end
        if (state_reg == ST_MODMUL)
        begin
            mod_prod_reg <= mod_prod_next;
        end
        pos_reg <= pos_next;
        if (state_reg == ST_WRAP && wrap_done)
        begin
            frac_reg <= pos_reg[7:0];
        end
        if (out_load)
        begin
            m_channel_reg <= ch_reg;
            m_sample_reg  <= m_sample_next;
            m_last_reg    <= last_reg;
        end
    end

    // per-channel smoothed depth; read at accept, written back after the slew
    always_ff @(posedge clk)
    begin
        if (clearing && ({1'b0, clr_ch} < (CH_AW + 1)'(CHANNELS)))
        begin
            depth_mem[clr_ch] <= '0;
        end
        else if (depth_we)
        begin
            depth_mem[ch_idx] <= depth_new_next;
        end
        if (accept)
        begin
            depth_rd_reg <= depth_mem[s_channel[CH_AW-1:0]];
        end
    end

    `ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_TARGET)
    `ASSERT_IMP(a_no_accept_clear, clk, rst_n, clearing, !s_ready)
    `ASSERT_IMP(a_depth_range, clk, rst_n, state_reg == ST_SLEW, depth_new_next <= DEPTH_ONE)
    `ASSERT_IMP(a_read_in_ring, clk, rst_n, ram_re, (AW + 1)'(rd_i0) < (AW + 1)'(BUFFER_DEPTH))

endmodule

`default_nettype wire

>>> design/modulated_delay_fm_unit.sv
// Modulated fractional delay line with linear interpolation, up to CHANNELS
// interleaved channels sharing one write position.
// Input stream: s_axis_* carries one channel's carrier, modulator and depth CV;
// s_axis_tlast marks the last channel of a frame and advances the write position.
// Output stream: m_axis_* returns one interpolated sample per input transaction,
// with the channel number and the tlast flag copied through.
// Settings come in over the APB port at byte addresses 0, 4, 8 and 12
// (base depth, CV attenuation, CV enable, nominal delay); write them while idle.
// The core steps through target, slew, modulator multiply, position, wrap and
// interpolate states before loading the output register, repeating the wrap step
// once for each fold of the read position back into the ring (up to two at the
// defaults). One item is in flight at a time, so a new item is taken only once
// the last one has been loaded into the output register.
// After reset the delay memory and the depth memory are swept to zero, one entry
// per cycle, over all CHANNELS*BUFFER_DEPTH delay addresses (65536 at the defaults); tready stays
// low during the sweep. A finished result waits in the output register while
// m_axis_tready is low; the core holds in its last step until that register frees.
`default_nettype none

module modulated_delay_fm_unit
    import mdfm_pkg::*;
#(
    parameter int BUFFER_DEPTH = 4096,
    parameter int CHANNELS     = 16,
    parameter int SAMPLE_BITS  = 16,
    localparam int IN_W        = ((4 + 3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((4 + SAMPLE_BITS + 7) / 8) * 8
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // channel, carrier_sample, mod_sample, depth_cv_sample (low to high)
    input  wire logic   [IN_W-1:0] s_axis_tdata,
    // frame_end
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out_channel, out_sample (low to high)
    output logic       [OUT_W-1:0] m_axis_tdata,
    // out_frame_end
    output logic                   m_axis_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int TOTAL  = CHANNELS * BUFFER_DEPTH;
    localparam int MEM_AW = $clog2(TOTAL);
    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cfg_t cfg;

    logic              clr_active_reg;
    logic              clr_active_next;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [MEM_AW-1:0] clr_cnt_next;

    logic                 core_we;
    logic    [MEM_AW-1:0] core_waddr;
    logic signed [SB-1:0] core_wdata;
    logic                 ram_we;
    logic    [MEM_AW-1:0] ram_waddr;
    logic signed [SB-1:0] ram_wdata;
    logic                 ram_re;
    logic    [MEM_AW-1:0] ram_raddr_a;
    logic    [MEM_AW-1:0] ram_raddr_b;
    logic signed [SB-1:0] ram_rdata_a;
    logic signed [SB-1:0] ram_rdata_b;

    logic           [3:0] m_channel;
    logic signed [SB-1:0] m_sample;

    mdfm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero sweep over the delay memory after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            if (clr_cnt_reg == MEM_AW'(TOTAL - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    assign ram_we    = clr_active_reg || core_we;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : core_waddr;
    assign ram_wdata = clr_active_reg ? '0 : core_wdata;

    mdfm_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CHANNELS     (CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .clearing    (clr_active_reg),
        .clr_ch      (clr_cnt_reg[CH_AW-1:0]),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_channel   (s_axis_tdata[3:0]),
        .s_carrier   (s_axis_tdata[4 +: SB]),
        .s_mod       (s_axis_tdata[4 + SB +: SB]),
        .s_cv        (s_axis_tdata[4 + 2 * SB +: SB]),
        .s_last      (s_axis_tlast),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_channel   (m_channel),
        .m_sample    (m_sample),
        .m_last      (m_axis_tlast),
        .ram_we      (core_we),
        .ram_waddr   (core_waddr),
        .ram_wdata   (core_wdata),
        .ram_re      (ram_re),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

    mdfm_delay_ram #(
        .DEPTH (TOTAL),
        .AW    (MEM_AW),
        .DW    (SB)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        m_axis_tdata          = '0;
        m_axis_tdata[3:0]     = m_channel;
        m_axis_tdata[4 +: SB] = m_sample;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_modulated_delay_fm_unit.sv
`timescale 1ns / 1ps

module tb_modulated_delay_fm_unit;
    import mdfm_pkg::*;

    localparam int    RING_LEN   = 4096;
    localparam int    NUM_CH     = 16;
    localparam longint SPAN      = 64'd4096 * 256;
    localparam int    CYCLE_LIMIT = 1000000;
    localparam int    SETTLE_CYCLES = 12;

    typedef struct {
        logic [3:0]         ch;
        logic signed [15:0] carrier;
        logic signed [15:0] modv;
        logic signed [15:0] cv;
        bit                 last;
    } fm_item_t;

    typedef struct {
        logic [3:0]         ch;
        logic signed [15:0] sample;
        bit                 last;
    } tap_t;

    typedef struct {
        logic [31:0] base;
        logic [31:0] atten;
        logic [31:0] cv_en;
        logic [31:0] nom;
    } cfg_words_t;

    typedef struct {
        int          cfg;
        logic [3:0]  ch;
        logic [15:0] carrier;
        logic [15:0] modv;
        logic [15:0] cv;
        bit          last;
        bit          known;
        logic [15:0] want;
    } vec_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // channel, carrier_sample, mod_sample, depth_cv_sample (low to high)
    logic [55:0] s_axis_tdata;
    // frame_end
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_channel, out_sample (low to high)
    logic [23:0] m_axis_tdata;
    // out_frame_end
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    modulated_delay_fm_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow state of the delay line
    logic signed [15:0] ring_mem [NUM_CH][RING_LEN];
    longint             depth_mem [NUM_CH];
    int                 wr_idx;
    logic [15:0]        cfg_base;
    logic signed [15:0] cfg_atten;
    bit                 cfg_cv_en;
    logic [19:0]        cfg_nom;

    tap_t     tap_queue [$];
    int       errors;
    int       cycles;
    int       send_gap_pct;
    int       rcv_gap_pct;
    int       hold_req;
    vec_row_t vectors [20];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= 40)
            $display("mismatch in %s: got %0d, expected %0d, at cycle %0d",
                     what, got, want, cycles);
    endtask

    function automatic tap_t predict_tap(input fm_item_t it);
        longint target;
        longint depth;
        longint offset;
        longint pos;
        longint a;
        longint b;
        int     i0;
        int     i1;
        int     frac;
        tap_t   t;
        t.ch = it.ch;
        t.last = it.last;
        ring_mem[it.ch][wr_idx] = it.carrier;

        target = longint'(cfg_base);
        if (cfg_cv_en)
            target += (longint'(it.cv) * longint'(cfg_atten)) >>> 14;
        if (target < 0)
            target = 0;
        if (target > longint'(DEPTH_ONE))
            target = longint'(DEPTH_ONE);

        // one-pole slew toward the target
        depth = depth_mem[it.ch];
        depth += ((target - depth) * SLEW_COEF + SLEW_ROUND) >>> 16;
        if (depth < 0)
            depth = 0;
        if (depth > longint'(DEPTH_ONE))
            depth = longint'(DEPTH_ONE);
        depth_mem[it.ch] = depth;

        offset = (longint'(it.modv) * depth * MOD_GAIN) >>> 20;
        pos = longint'(wr_idx) * 256 - longint'(cfg_nom) + offset;
        pos = pos % SPAN;
        if (pos < 0)
            pos += SPAN;
        i0 = int'(pos >>> 8);
        frac = int'(pos & 255);
        i1 = (i0 + 1) % RING_LEN;
        a = longint'(ring_mem[it.ch][i0]);
        b = longint'(ring_mem[it.ch][i1]);
        t.sample = 16'(a + ((longint'(frac) * (b - a)) >>> 8));

        if (it.last)
            wr_idx = (wr_idx + 1) % RING_LEN;
        return t;
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tap_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(input cfg_words_t w);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_BASE_DEPTH, w.base);
        apb_write(REG_CV_ATTEN, w.atten);
        apb_write(REG_CV_ENABLED, w.cv_en);
        apb_write(REG_NOMINAL_DELAY, w.nom);
        cfg_base = w.base[15:0];
        cfg_atten = w.atten[15:0];
        cfg_cv_en = w.cv_en[0];
        cfg_nom = w.nom[19:0];
    endtask

    function automatic cfg_words_t random_cfg();
        cfg_words_t w;
        bit junk;
        junk = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: w.base = 32'd0;
            1: w.base = 32'd32768;
            2: w.base = 32'd65535;
            default: w.base = $urandom_range(0, 32768);
        endcase
        case ($urandom_range(0, 3))
            0: w.atten = 32'hFFFF8000;
            1: w.atten = 32'h00007FFF;
            default: w.atten = {16'h0000, 16'($urandom)};
        endcase
        w.cv_en = 32'($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 4))
            0: w.nom = 32'd0;
            1: w.nom = 32'hFFFFF;
            2: w.nom = $urandom_range(0, 1048575);
            default: w.nom = $urandom_range(0, 256 * 64);
        endcase
        // bits above each register's width must be ignored
        if (junk)
        begin
            w.base[31:16] = 16'($urandom);
            w.atten[31:16] = 16'($urandom);
            w.cv_en[31:1] = 31'($urandom);
            w.nom[31:20] = 12'($urandom);
        end
        return w;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 127) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input fm_item_t it, input bit known, input logic [15:0] want);
        tap_t t;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'h0, it.cv, it.modv, it.carrier, it.ch};
        s_axis_tlast <= it.last;
        do @(posedge clk); while (!s_axis_tready);
        t = predict_tap(it);
        if (known)
            t.sample = want;
        tap_queue.push_back(t);
    endtask

    task automatic run_phase(input int n_items, input int n_ch, input int noise_pct,
                             input int tx_gap, input int rx_gap, input int hold,
                             input int drain_at);
        fm_item_t it;
        int       frame_ch;
        frame_ch = 0;
        send_gap_pct = tx_gap;
        rcv_gap_pct = rx_gap;
        hold_req = hold;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == drain_at)
                wait_drained();
            it.carrier = pick_sample();
            it.modv = pick_sample();
            it.cv = pick_sample();
            if ($urandom_range(0, 99) < noise_pct)
            begin
                it.ch = 4'($urandom);
                it.last = 1'($urandom_range(0, 1));
            end
            else
            begin
                it.ch = 4'(frame_ch);
                it.last = (frame_ch == n_ch - 1);
                // occasionally drop the frame marker
                if (it.last && $urandom_range(0, 19) == 0)
                    it.last = 1'b0;
                frame_ch = (frame_ch == n_ch - 1) ? 0 : frame_ch + 1;
            end
            send_item(it, 1'b0, 16'h0000);
        end
    endtask

    task automatic check_tap();
        tap_t want;
        if (tap_queue.size() == 0)
        begin
            report_mismatch("unexpected result channel", longint'(m_axis_tdata[3:0]), -1);
            return;
        end
        want = tap_queue.pop_front();
        if (m_axis_tdata[3:0] !== want.ch)
            report_mismatch("out_channel", longint'(m_axis_tdata[3:0]), longint'(want.ch));
        if (m_axis_tdata[19:4] !== want.sample)
            report_mismatch("out_sample", longint'($signed(m_axis_tdata[19:4])),
                            longint'(want.sample));
        if (m_axis_tlast !== want.last)
            report_mismatch("out_frame_end", longint'(m_axis_tlast), longint'(want.last));
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_tap();
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req > 0)
            begin
                // long hold-off so the core backs up into its input
                stall_left = hold_req - 1;
                hold_req = 0;
                m_axis_tready <= 1'b0;
            end
            else if (rcv_gap_pct > 0 && $urandom_range(0, 99) < rcv_gap_pct)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        cfg_words_t cfg_sets [4];
        fm_item_t   it;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        hold_req = 0;
        send_gap_pct = 30;
        rcv_gap_pct = 30;
        wr_idx = 0;
        cfg_base = 16'd0;
        cfg_atten = 16'sd0;
        cfg_cv_en = 1'b0;
        cfg_nom = NOM_RESET;
        foreach (depth_mem[c])
            depth_mem[c] = 0;
        foreach (ring_mem[c, j])
            ring_mem[c][j] = 16'sd0;

        cfg_sets[0] = '{32'd0, 32'd0, 32'd0, 32'd0};
        cfg_sets[1] = '{32'd32768, 32'h00007FFF, 32'd1, 32'd0};
        cfg_sets[2] = '{32'hABCD0000, 32'hFFFF8000, 32'hFFFFFFFF, 32'h000FFFFF};
        cfg_sets[3] = '{32'd0, 32'd0, 32'd0, 32'd61440};

        // defaults after reset read untouched, zeroed ring entries; zero delay
        // with zero depth returns the sample just written
        vectors = '{
            '{-1, 4'd0,  16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000},
            '{-1, 4'd15, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000},
            '{-1, 4'd7,  16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000},
            '{-1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000},
            '{0,  4'd0,  16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{-1, 4'd15, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h8000},
            '{-1, 4'd3,  16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h0000},
            '{-1, 4'd9,  16'h5A5A, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h5A5A},
            '{-1, 4'd15, 16'hA5A5, 16'h1111, 16'hEEEE, 1'b1, 1'b1, 16'hA5A5},
            '{1,  4'd0,  16'h4000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'hC000, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd1,  16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'h0100, 16'h4000, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'h2222, 16'hC000, 16'h0000, 1'b1, 1'b0, 16'h0000},
            '{2,  4'd0,  16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000},
            '{-1, 4'd5,  16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'h1357, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
            '{3,  4'd15, 16'h2468, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000},
            '{-1, 4'd0,  16'h7FFF, 16'h0000, 16'h7FFF, 1'b1, 1'b0, 16'h0000}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vectors[k])
        begin
            if (vectors[k].cfg >= 0)
                apply_config(cfg_sets[vectors[k].cfg]);
            it.ch = vectors[k].ch;
            it.carrier = vectors[k].carrier;
            it.modv = vectors[k].modv;
            it.cv = vectors[k].cv;
            it.last = vectors[k].last;
            send_item(it, vectors[k].known, vectors[k].want);
        end

        apply_config(random_cfg());
        run_phase(200, 16, 10, 30, 30, 0, -1);
        apply_config(cfg_sets[1]);
        run_phase(500, 1, 5, 20, 20, 400, -1);
        apply_config(random_cfg());
        run_phase(150, 4, 15, 40, 40, 0, 75);
        apply_config(cfg_sets[2]);
        run_phase(150, 8, 30, 30, 30, 0, -1);
        apply_config(random_cfg());
        run_phase(200, 2, 10, 0, 50, 0, -1);
        apply_config(random_cfg());
        run_phase(200, 16, 10, 50, 0, 0, -1);
        apply_config(random_cfg());
        run_phase(200, 3, 10, 30, 30, 0, -1);
        apply_config(random_cfg());
        run_phase(230, 1, 10, 0, 0, 0, -1);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> modulated_delay_fm_unit.f
+incdir+design
design/mdfm_pkg.sv
design/mdfm_cfg.sv
design/mdfm_delay_ram.sv
design/mdfm_core.sv
design/modulated_delay_fm_unit.sv
tb/sv/tb_modulated_delay_fm_unit.sv
